// ===== rtl/irq_event_count_dispatcher_core_defines.svh =====
// ----------------------------------------------------------------------------
// Assertion macros used by the checker file of the dispatcher.
// They expect signals named clk and rst in the scope where they are used.
// ----------------------------------------------------------------------------
`ifndef IRQ_EVENT_COUNT_DISPATCHER_CORE_DEFINES_SVH
`define IRQ_EVENT_COUNT_DISPATCHER_CORE_DEFINES_SVH

// Same-cycle implication, disabled while reset is high.
`define IECD_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed: implication");

// Next-cycle implication, disabled while reset is high.
`define IECD_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");

`endif

// ===== rtl/iecd_pkg.sv =====
// ----------------------------------------------------------------------------
// iecd_pkg
// Shared constants and types of the interrupt event count dispatcher.
// ----------------------------------------------------------------------------
package iecd_pkg;

  localparam int NUM_LINES = 32;
  localparam int LINE_W    = $clog2(NUM_LINES);
  localparam int COUNT_W   = 32;
  localparam int MASK_W    = 32;

  localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

  // Request opcodes.
  localparam logic OP_RAISE   = 1'b0;
  localparam logic OP_SERVICE = 1'b1;

  // Read port request of the counter memory.
  typedef struct packed {
    logic              en;
    logic [LINE_W-1:0] addr;
  } ram_rd_t;

  // Write port request of the counter memory.
  typedef struct packed {
    logic               en;
    logic [LINE_W-1:0]  addr;
    logic [COUNT_W-1:0] data;
  } ram_wr_t;

endpackage

// ===== rtl/iecd_count_ram.sv =====
// ----------------------------------------------------------------------------
// iecd_count_ram
// Event counter memory, one word per line, registered read.
// Entries never written since reset read as zero through per-entry valid bits.
// ----------------------------------------------------------------------------
module iecd_count_ram (
  input  logic                         clk,
  input  logic                         rst,
  input  iecd_pkg::ram_rd_t            rd,
  input  iecd_pkg::ram_wr_t            wr,
  output logic [iecd_pkg::COUNT_W-1:0] rd_data
);

  logic [iecd_pkg::COUNT_W-1:0] mem [iecd_pkg::NUM_LINES];
  logic [iecd_pkg::NUM_LINES-1:0] entry_valid;
  logic [iecd_pkg::COUNT_W-1:0] rd_word;
  logic                         rd_word_valid;

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
    if (rd.en) begin
      rd_word <= mem[rd.addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      entry_valid   <= '0;
      rd_word_valid <= 1'b0;
    end else begin
      if (wr.en) begin
        entry_valid[wr.addr] <= 1'b1;
      end
      if (rd.en) begin
        rd_word_valid <= entry_valid[rd.addr];
      end
    end
  end

  assign rd_data = rd_word_valid ? rd_word : '0;

endmodule

// ===== rtl/iecd_pick.sv =====
// ----------------------------------------------------------------------------
// iecd_pick
// Priority picker: highest-numbered line that is pending and subscribed.
// ----------------------------------------------------------------------------
module iecd_pick (
  input  logic [iecd_pkg::NUM_LINES-1:0] pending,
  input  logic [iecd_pkg::MASK_W-1:0]    mask,
  output logic                           found,
  output logic [iecd_pkg::LINE_W-1:0]    idx
);

  logic [iecd_pkg::NUM_LINES-1:0] eligible;

  assign eligible = pending & mask;
  assign found    = |eligible;

  // Later iterations override earlier ones, so the highest set bit wins.
  always_comb begin
    idx = '0;
    for (int i = 0; i < iecd_pkg::NUM_LINES; i++) begin
      if (eligible[i]) begin
        idx = iecd_pkg::LINE_W'(i);
      end
    end
  end

endmodule

// ===== rtl/irq_event_count_dispatcher_core.sv =====
// ----------------------------------------------------------------------------
// irq_event_count_dispatcher_core: a request is accepted in IDLE, where its
// counter is read through the memory's registered read, and its result is
// registered at the end of UPDATE, with the write-back; no new request is
// taken until then, and a result left waiting holds the input off until it
// is taken. Reset clears pending bits, mask and counters (via valid bits); no clearing pass is needed.
// ----------------------------------------------------------------------------
module irq_event_count_dispatcher_core (
  input  logic                         clk,
  input  logic                         rst,
  // Request channel.
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic                         opcode,
  input  logic [iecd_pkg::LINE_W-1:0]  line,
  // Result channel.
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic                         served,
  output logic [iecd_pkg::LINE_W-1:0]  served_line,
  output logic [iecd_pkg::COUNT_W-1:0] remaining_count,
  output logic                         more_pending,
  // Subscription mask register.
  input  logic                         cfg_we,
  input  logic [iecd_pkg::MASK_W-1:0]  cfg_wdata
);

  // Two-state sequencer. In IDLE a request is taken and the counter of its
  // target line is read. In UPDATE the read word is modified, written back and
  // the result is loaded into the output register. If that register still
  // holds a result that has not been taken, UPDATE waits; the read word stays
  // put because no new read is issued.
  typedef enum logic [1:0] {
    S_IDLE   = 2'b01,
    S_UPDATE = 2'b10
  } state_t;

  state_t state, state_next;

  logic [iecd_pkg::MASK_W-1:0]    subscription_mask;
  logic [iecd_pkg::NUM_LINES-1:0] pending_bits;
  logic [iecd_pkg::NUM_LINES-1:0] pending_next;

  // Request held across the UPDATE state.
  logic                        op_q;
  logic [iecd_pkg::LINE_W-1:0] target_q;
  logic                        hit_q;

  logic                        accept;
  logic                        pick_found;
  logic [iecd_pkg::LINE_W-1:0] pick_idx;
  logic                        out_free;
  logic                        finish;

  iecd_pkg::ram_rd_t            ram_rd;
  iecd_pkg::ram_wr_t            ram_wr;
  logic [iecd_pkg::COUNT_W-1:0] count_rd;
  logic [iecd_pkg::COUNT_W-1:0] count_new;

  assign in_ready = (state == S_IDLE);
  assign accept   = in_valid && in_ready;
  assign out_free = !out_valid || out_ready;
  assign finish   = (state == S_UPDATE) && out_free;

  // The service pick is made from the pending bits as they stand at accept
  // time; nothing else changes them while the request is in flight.
  iecd_pick u_pick (
    .pending (pending_bits),
    .mask    (subscription_mask),
    .found   (pick_found),
    .idx     (pick_idx)
  );

  assign ram_rd.en   = accept;
  assign ram_rd.addr = (opcode == iecd_pkg::OP_SERVICE) ? pick_idx : line;

  iecd_count_ram u_count_ram (
    .clk     (clk),
    .rst     (rst),
    .rd      (ram_rd),
    .wr      (ram_wr),
    .rd_data (count_rd)
  );

  // Counter update: raise saturates at the top, service stops at zero and
  // drops the pending bit once the counter is empty.
  always_comb begin
    pending_next = pending_bits;
    count_new    = count_rd;
    if (op_q == iecd_pkg::OP_RAISE) begin
      if (count_rd != iecd_pkg::COUNT_MAX) begin
        count_new = count_rd + iecd_pkg::COUNT_W'(1);
      end
      if (hit_q) begin
        pending_next[target_q] = 1'b1;
      end
    end else begin
      if (count_rd != '0) begin
        count_new = count_rd - iecd_pkg::COUNT_W'(1);
      end
      if (hit_q && (count_new == '0)) begin
        pending_next[target_q] = 1'b0;
      end
    end
  end

  assign ram_wr.en   = finish && hit_q;
  assign ram_wr.addr = target_q;
  assign ram_wr.data = count_new;

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          state_next = S_UPDATE;
        end
      end
      S_UPDATE: begin
        if (out_free) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (rst) begin
      state             <= S_IDLE;
      subscription_mask <= '0;
      pending_bits      <= '0;
      out_valid         <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_we) begin
        subscription_mask <= cfg_wdata;
      end
      if (finish) begin
        pending_bits <= pending_next;
        out_valid    <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Request and result payload.
  always_ff @(posedge clk) begin
    if (accept) begin
      op_q     <= opcode;
      target_q <= ram_rd.addr;
      // Every 5-bit line number addresses a real line, so a raise always hits.
      hit_q    <= (opcode == iecd_pkg::OP_SERVICE) ? pick_found : 1'b1;
    end
    if (finish) begin
      served          <= (op_q == iecd_pkg::OP_SERVICE) && hit_q;
      served_line     <= hit_q ? target_q : '0;
      remaining_count <= hit_q ? count_new : '0;
      more_pending    <= |(pending_next & subscription_mask);
    end
  end

endmodule

// ===== rtl/iecd_checker.sv =====
// ----------------------------------------------------------------------------
// iecd_checker
// Port-level checks of the dispatcher, attached to the top level by bind.
// ----------------------------------------------------------------------------
`include "irq_event_count_dispatcher_core_defines.svh"

module iecd_checker (
  input logic                         clk,
  input logic                         rst,
  input logic                         in_valid,
  input logic                         in_ready,
  input logic                         out_valid,
  input logic                         out_ready,
  input logic                         served,
  input logic [iecd_pkg::COUNT_W-1:0] remaining_count,
  input logic                         more_pending
);

  // A result that is not taken stays offered.
  `IECD_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid)

  // Requests are handled one at a time: no request is taken right after one.
  `IECD_ASSERT_NEXT(a_one_at_a_time, in_valid && in_ready, !in_ready)

  // A served line whose counter is not yet empty is still eligible.
  `IECD_ASSERT_IMPL(a_served_left, out_valid && served && (remaining_count != '0), more_pending)

  // No result is offered right after reset.
  `IECD_ASSERT_IMPL(a_reset_empty, $past(rst), !out_valid)

endmodule

bind irq_event_count_dispatcher_core iecd_checker u_iecd_checker (
  .clk             (clk),
  .rst             (rst),
  .in_valid        (in_valid),
  .in_ready        (in_ready),
  .out_valid       (out_valid),
  .out_ready       (out_ready),
  .served          (served),
  .remaining_count (remaining_count),
  .more_pending    (more_pending)
);
